// ===== design/lcdnw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Shared types, timing constants and interval-forming functions for the
// character LCD 4-bit write sequencer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

	// Request codes carried on cmd.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_INIT  = 1'b1;

	localparam int NIB_W  = 4;
	localparam int BYTE_W = 8;
	localparam int HOLD_W = 15;

	// Interval counts of one request.
	localparam int INIT_LEN  = 46;
	localparam int STEP_W    = $clog2(INIT_LEN);
	localparam int SUB_W     = 3;
	localparam int WR_LEN    = 6;
	localparam int WR_SLOW_LEN = 7;

	// Interval durations in microseconds.
	localparam logic [HOLD_W-1:0] PULSE_SETUP_US = HOLD_W'(1);
	localparam logic [HOLD_W-1:0] PULSE_HIGH_US  = HOLD_W'(1);
	localparam logic [HOLD_W-1:0] PULSE_TAIL_US  = HOLD_W'(45);
	localparam logic [HOLD_W-1:0] SLOW_INSTR_US  = HOLD_W'(2000);
	localparam logic [HOLD_W-1:0] POWERUP_US     = HOLD_W'(20000);
	localparam logic [HOLD_W-1:0] INIT_WAIT1_US  = HOLD_W'(5000);
	localparam logic [HOLD_W-1:0] INIT_WAIT2_US  = HOLD_W'(200);

	localparam logic [BYTE_W-1:0] HIGH_NIBBLE_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] SLOW_LIMIT       = 8'h04;

	// Power-up instruction words, in the order they are sent.
	localparam logic [BYTE_W-1:0] INIT_FUNC_SET  = 8'h28;
	localparam logic [BYTE_W-1:0] INIT_DISP_OFF  = 8'h08;
	localparam logic [BYTE_W-1:0] INIT_CLEAR     = 8'h01;
	localparam logic [BYTE_W-1:0] INIT_DISP_ON   = 8'h0C;
	localparam logic [BYTE_W-1:0] INIT_HOME_ADDR = 8'h80;

	// Bare nibbles of the wake-up pulses.
	localparam logic [NIB_W-1:0] WAKE_NIB = 4'h3;
	localparam logic [NIB_W-1:0] MODE_NIB = 4'h2;

	// First step of each power-up instruction word.
	localparam logic [STEP_W-1:0] INIT_BYTE0 = STEP_W'(15);
	localparam logic [STEP_W-1:0] INIT_BYTE1 = STEP_W'(21);
	localparam logic [STEP_W-1:0] INIT_BYTE2 = STEP_W'(27);
	localparam logic [STEP_W-1:0] INIT_BYTE3 = STEP_W'(34);
	localparam logic [STEP_W-1:0] INIT_BYTE4 = STEP_W'(40);

	typedef struct packed {
		logic              cmd;
		logic [BYTE_W-1:0] byte_value;
		logic              is_char;
	} req_t;

	typedef struct packed {
		logic [NIB_W-1:0]  data_nibble;
		logic              reg_select;
		logic              enable_pin;
		logic [HOLD_W-1:0] hold_us;
		logic              last;
	} interval_t;

	// Sequencer state handed to the interval decoder.
	typedef struct packed {
		logic              active;
		logic [STEP_W-1:0] step;
		req_t              req;
	} seq_stat_t;

	// One enable pulse: setup, strobe high, tail.
	function automatic interval_t pulse_interval(input logic [NIB_W-1:0] nib,
			input logic rs, input logic [1:0] phase);
		interval_t iv;
		iv.data_nibble = nib;
		iv.reg_select  = rs;
		iv.last        = 1'b0;
		unique case (phase)
			2'd0: begin
				iv.enable_pin = 1'b0;
				iv.hold_us    = PULSE_SETUP_US;
			end
			2'd1: begin
				iv.enable_pin = 1'b1;
				iv.hold_us    = PULSE_HIGH_US;
			end
			default: begin
				iv.enable_pin = 1'b0;
				iv.hold_us    = PULSE_TAIL_US;
			end
		endcase
		return iv;
	endfunction

	// Interval sub of a byte write: two pulses, then the slow-instruction wait.
	function automatic interval_t byte_interval(input logic [BYTE_W-1:0] value,
			input logic rs, input logic [SUB_W-1:0] sub);
		interval_t iv;
		logic [NIB_W-1:0] hi;
		logic [NIB_W-1:0] lo;
		hi = NIB_W'((value & HIGH_NIBBLE_MASK) >> NIB_W);
		lo = value[NIB_W-1:0];
		priority if (sub < SUB_W'(3)) begin
			iv = pulse_interval(hi, rs, sub[1:0]);
		end else if (sub < SUB_W'(WR_LEN)) begin
			iv = pulse_interval(lo, rs, 2'(sub - SUB_W'(3)));
		end else begin
			iv.data_nibble = lo;
			iv.reg_select  = rs;
			iv.enable_pin  = 1'b0;
			iv.hold_us     = SLOW_INSTR_US;
			iv.last        = 1'b0;
		end
		return iv;
	endfunction

endpackage

// ===== design/lcdnw_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcdnw_ctrl
// Request register and interval step counter; decides when a new request
// may be taken.
// ----------------------------------------------------------------------------
module lcdnw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lcdnw_pkg::req_t     req_in,
	input  logic                last_step,
	output logic                busy,
	output lcdnw_pkg::seq_stat_t stat
);

	logic                         active_q;
	logic [lcdnw_pkg::STEP_W-1:0] step_q;
	lcdnw_pkg::req_t              req_s1;
	logic                         accept;

	// The final interval frees the request register, so a new word can
	// follow it without a gap.
	assign busy   = active_q && !last_step;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			step_q   <= '0;
		end else if (active_q) begin
			active_q <= !last_step;
			step_q   <= step_q + lcdnw_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_in;
		end
	end

	assign stat.active = active_q;
	assign stat.step   = step_q;
	assign stat.req    = req_s1;

endmodule

// ===== design/lcdnw_decode.sv =====
// ----------------------------------------------------------------------------
// lcdnw_decode
// Forms the pin levels and hold time of the current interval from the
// held request and the step number.
// ----------------------------------------------------------------------------
module lcdnw_decode (
	input  lcdnw_pkg::seq_stat_t stat,
	output lcdnw_pkg::interval_t iv,
	output logic                 last_step
);

	logic [lcdnw_pkg::STEP_W-1:0] step;
	logic                         slow;
	lcdnw_pkg::interval_t         iv_init;
	lcdnw_pkg::interval_t         iv_wr;

	assign step = stat.step;
	assign slow = !stat.req.is_char && (stat.req.byte_value < lcdnw_pkg::SLOW_LIMIT);

	assign iv_wr = lcdnw_pkg::byte_interval(stat.req.byte_value, stat.req.is_char,
			step[lcdnw_pkg::SUB_W-1:0]);

	always_comb begin
		priority if (step == '0) begin
			iv_init.data_nibble = '0;
			iv_init.reg_select  = 1'b0;
			iv_init.enable_pin  = 1'b0;
			iv_init.hold_us     = lcdnw_pkg::POWERUP_US;
			iv_init.last        = 1'b0;
		end else if (step < lcdnw_pkg::STEP_W'(4)) begin
			iv_init = lcdnw_pkg::pulse_interval(lcdnw_pkg::WAKE_NIB, 1'b0,
					2'(step - lcdnw_pkg::STEP_W'(1)));
		end else if (step == lcdnw_pkg::STEP_W'(4)) begin
			iv_init.data_nibble = lcdnw_pkg::WAKE_NIB;
			iv_init.reg_select  = 1'b0;
			iv_init.enable_pin  = 1'b0;
			iv_init.hold_us     = lcdnw_pkg::INIT_WAIT1_US;
			iv_init.last        = 1'b0;
		end else if (step < lcdnw_pkg::STEP_W'(8)) begin
			iv_init = lcdnw_pkg::pulse_interval(lcdnw_pkg::WAKE_NIB, 1'b0,
					2'(step - lcdnw_pkg::STEP_W'(5)));
		end else if (step == lcdnw_pkg::STEP_W'(8)) begin
			iv_init.data_nibble = lcdnw_pkg::WAKE_NIB;
			iv_init.reg_select  = 1'b0;
			iv_init.enable_pin  = 1'b0;
			iv_init.hold_us     = lcdnw_pkg::INIT_WAIT2_US;
			iv_init.last        = 1'b0;
		end else if (step < lcdnw_pkg::STEP_W'(12)) begin
			iv_init = lcdnw_pkg::pulse_interval(lcdnw_pkg::WAKE_NIB, 1'b0,
					2'(step - lcdnw_pkg::STEP_W'(9)));
		end else if (step < lcdnw_pkg::INIT_BYTE0) begin
			iv_init = lcdnw_pkg::pulse_interval(lcdnw_pkg::MODE_NIB, 1'b0,
					2'(step - lcdnw_pkg::STEP_W'(12)));
		end else if (step < lcdnw_pkg::INIT_BYTE1) begin
			iv_init = lcdnw_pkg::byte_interval(lcdnw_pkg::INIT_FUNC_SET, 1'b0,
					lcdnw_pkg::SUB_W'(step - lcdnw_pkg::INIT_BYTE0));
		end else if (step < lcdnw_pkg::INIT_BYTE2) begin
			iv_init = lcdnw_pkg::byte_interval(lcdnw_pkg::INIT_DISP_OFF, 1'b0,
					lcdnw_pkg::SUB_W'(step - lcdnw_pkg::INIT_BYTE1));
		end else if (step < lcdnw_pkg::INIT_BYTE3) begin
			iv_init = lcdnw_pkg::byte_interval(lcdnw_pkg::INIT_CLEAR, 1'b0,
					lcdnw_pkg::SUB_W'(step - lcdnw_pkg::INIT_BYTE2));
		end else if (step < lcdnw_pkg::INIT_BYTE4) begin
			iv_init = lcdnw_pkg::byte_interval(lcdnw_pkg::INIT_DISP_ON, 1'b0,
					lcdnw_pkg::SUB_W'(step - lcdnw_pkg::INIT_BYTE3));
		end else begin
			iv_init = lcdnw_pkg::byte_interval(lcdnw_pkg::INIT_HOME_ADDR, 1'b0,
					lcdnw_pkg::SUB_W'(step - lcdnw_pkg::INIT_BYTE4));
		end
	end

	always_comb begin
		if (stat.req.cmd == lcdnw_pkg::CMD_INIT) begin
			last_step = stat.active && (step == lcdnw_pkg::STEP_W'(lcdnw_pkg::INIT_LEN - 1));
			iv        = iv_init;
		end else begin
			last_step = stat.active && (slow ?
					(step == lcdnw_pkg::STEP_W'(lcdnw_pkg::WR_SLOW_LEN - 1)) :
					(step == lcdnw_pkg::STEP_W'(lcdnw_pkg::WR_LEN - 1)));
			iv        = iv_wr;
		end
		iv.last = last_step;
	end

endmodule

// ===== design/char_lcd_nibble_write_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_top
// Expands one write or initialize request into the timed pin intervals of a
// character LCD on a 4-bit data bus, one interval per clock.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Fields
//  request   start / busy         cmd, byte_value, is_char
//  interval  strobe (no stall)    data_nibble, reg_select, enable_pin, hold_us, last
//
//  A request emits one interval word per clock: 6 for a byte write, 7 for an
//  instruction byte below 4, 46 for initialization. The step counter sets the pace.
//  The first word is registered by the step counter and then by the output
//  register before it is on the ports. busy drops while the final word is still
//  in the decoder, ahead of the output register, so requests follow back to back.
//  Reset clears the sequencer and the strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [lcdnw_pkg::BYTE_W-1:0]  byte_value,
	input  logic                          is_char,
	output logic                          strobe,
	output logic [lcdnw_pkg::NIB_W-1:0]   data_nibble,
	output logic                          reg_select,
	output logic                          enable_pin,
	output logic [lcdnw_pkg::HOLD_W-1:0]  hold_us,
	output logic                          last
);

	lcdnw_pkg::req_t      req_in;
	lcdnw_pkg::seq_stat_t stat;
	lcdnw_pkg::interval_t iv;
	lcdnw_pkg::interval_t iv_s2;
	logic                 last_step;
	logic                 strobe_q;

	assign req_in.cmd        = cmd;
	assign req_in.byte_value = byte_value;
	assign req_in.is_char    = is_char;

	lcdnw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_in   (req_in),
		.last_step(last_step),
		.busy     (busy),
		.stat     (stat)
	);

	lcdnw_decode u_decode (
		.stat     (stat),
		.iv       (iv),
		.last_step(last_step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= stat.active;
		end
	end

	always_ff @(posedge clk) begin
		iv_s2 <= iv;
	end

	assign strobe      = strobe_q;
	assign data_nibble = iv_s2.data_nibble;
	assign reg_select  = iv_s2.reg_select;
	assign enable_pin  = iv_s2.enable_pin;
	assign hold_us     = iv_s2.hold_us;
	assign last        = iv_s2.last;

`ifndef ASSERT_OFF
	// Every accepted request raises strobe for its first word.
	a_accept_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 strobe)
		else $error("accepted request produced no interval word");

	// A sequence is never broken before its final word.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("interval sequence stopped before its last word");

	// The enable strobe is always high for exactly one microsecond.
	a_pulse_width: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && enable_pin) |-> (hold_us == lcdnw_pkg::PULSE_HIGH_US))
		else $error("enable high interval has the wrong duration");

	// The sequencer never runs past the longest request.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.active |-> (stat.step < lcdnw_pkg::STEP_W'(lcdnw_pkg::INIT_LEN)))
		else $error("step counter ran past the end of the sequence");
`endif

endmodule
